// ===== rtl/core/nearest_spot_selector_defines.svh =====
// assertion macros used by nearest_spot_selector.sv
`ifndef NEAREST_SPOT_SELECTOR_DEFINES_SVH
`define NEAREST_SPOT_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is low
`define NSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define NSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/nss_pkg.sv =====
package nss_pkg;

    localparam int unsigned OFS_W   = 12;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned PEAK_W  = 12;
    localparam int unsigned FRAC_W  = 4;
    localparam int unsigned ABS_W   = COORD_W + 1;
    localparam int unsigned HALF_W  = PEAK_W - 1;
    localparam int unsigned SCORE_W = 21;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PIX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PEAK  = 3'd5;

    typedef struct packed {
        logic [OFS_W-1:0]   win_x;
        logic [OFS_W-1:0]   win_y;
        logic [COORD_W-1:0] ref_x;
        logic [COORD_W-1:0] ref_y;
        logic [PIX_W-1:0]   ref_pix;
        logic [PEAK_W-1:0]  ref_peak;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        logic [PEAK_W-1:0]  peak;
    } t_group;

    // per-group distance terms, already in their unscaled form
    typedef struct packed {
        logic [ABS_W-1:0]  dx;
        logic [ABS_W-1:0]  dy;
        logic [PIX_W-1:0]  dpix;
        logic [HALF_W-1:0] dpeak;
    } t_terms;

endpackage

// ===== rtl/core/nss_terms.sv =====
module nss_terms (
    input  nss_pkg::t_cfg   i_cfg,
    input  nss_pkg::t_group i_group,
    output nss_pkg::t_terms o_terms
);

    logic [nss_pkg::ABS_W-1:0]  ax;
    logic [nss_pkg::ABS_W-1:0]  ay;
    logic [nss_pkg::ABS_W-1:0]  rx;
    logic [nss_pkg::ABS_W-1:0]  ry;
    logic [nss_pkg::HALF_W-1:0] g_half;
    logic [nss_pkg::HALF_W-1:0] r_half_peak;
    logic                       use_shape;

    // absolute centroid: whole-pixel window edge moved to q12.4, plus local centroid
    assign ax = {1'b0, i_cfg.win_x, {nss_pkg::FRAC_W{1'b0}}} + {1'b0, i_group.x};
    assign ay = {1'b0, i_cfg.win_y, {nss_pkg::FRAC_W{1'b0}}} + {1'b0, i_group.y};
    assign rx = {1'b0, i_cfg.ref_x};
    assign ry = {1'b0, i_cfg.ref_y};

    assign g_half      = i_group.peak[nss_pkg::PEAK_W-1:1];
    assign r_half_peak = i_cfg.ref_peak[nss_pkg::PEAK_W-1:1];
    assign use_shape   = (i_cfg.ref_pix != '0);

    always_comb begin
        o_terms.dx = (ax >= rx) ? (ax - rx) : (rx - ax);
        o_terms.dy = (ay >= ry) ? (ay - ry) : (ry - ay);
        o_terms.dpix  = '0;
        o_terms.dpeak = '0;
        // pixel count and peak only count when a reference count is known
        if (use_shape) begin
            o_terms.dpix = (i_group.pix >= i_cfg.ref_pix) ?
                           (i_group.pix - i_cfg.ref_pix) : (i_cfg.ref_pix - i_group.pix);
            o_terms.dpeak = (g_half >= r_half_peak) ?
                            (g_half - r_half_peak) : (r_half_peak - g_half);
        end
    end

endmodule

// ===== rtl/core/nearest_spot_selector.sv =====
// result: captured in the output register when the frame's last group leaves the compare stage
// throughput: one group per cycle sustained; input, distance and compare stages each register
// the item, and only a held result back-pressures the pipe
// reset: synchronous, active low; clears config registers, pipeline valids, the frame's running
// minimum (all ones), best index, group count and overflow flag
`include "nearest_spot_selector_defines.svh"

module nearest_spot_selector #(
    parameter int unsigned MAX_GROUPS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_wr_en,
    input  logic [nss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // group request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [nss_pkg::COORD_W-1:0]        i_group_x,
    input  logic [nss_pkg::COORD_W-1:0]        i_group_y,
    input  logic [nss_pkg::PIX_W-1:0]          i_group_pixels,
    input  logic [nss_pkg::PEAK_W-1:0]         i_group_peak,
    input  logic                               i_last_group,
    // result request channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [nss_pkg::INDEX_W-1:0]        o_best_index,
    output logic [nss_pkg::SCORE_W-1:0]        o_best_score,
    output logic                               o_overflow
);

    localparam int unsigned CNT_W = $clog2(MAX_GROUPS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GROUPS);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    nss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                nss_pkg::CFG_WIN_X:    r_cfg.win_x    <= i_cfg_data[nss_pkg::OFS_W-1:0];
                nss_pkg::CFG_WIN_Y:    r_cfg.win_y    <= i_cfg_data[nss_pkg::OFS_W-1:0];
                nss_pkg::CFG_REF_X:    r_cfg.ref_x    <= i_cfg_data[nss_pkg::COORD_W-1:0];
                nss_pkg::CFG_REF_Y:    r_cfg.ref_y    <= i_cfg_data[nss_pkg::COORD_W-1:0];
                nss_pkg::CFG_REF_PIX:  r_cfg.ref_pix  <= i_cfg_data[nss_pkg::PIX_W-1:0];
                nss_pkg::CFG_REF_PEAK: r_cfg.ref_peak <= i_cfg_data[nss_pkg::PEAK_W-1:0];
                default: ; // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake chain: result register <- compare stage <- distance stage <- input stage
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s1_last;
    logic r_s2_valid, r_s2_last;
    logic r_out_valid;
    nss_pkg::t_group r_s1_group;
    nss_pkg::t_terms r_s2_terms;
    nss_pkg::t_terms terms;

    logic out_free, s2_go, s2_ready, s1_go, s1_ready, in_take;

    assign out_free = !r_out_valid || i_out_ready;
    // a non-last group only touches the running state, so only a last one waits
    assign s2_go    = r_s2_valid && (!r_s2_last || out_free);
    assign s2_ready = !r_s2_valid || s2_go;
    assign s1_go    = r_s1_valid && s2_ready;
    assign s1_ready = !r_s1_valid || s1_go;
    assign in_take  = i_in_valid && s1_ready;
    assign o_in_ready = s1_ready;

    // stage 1: capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_group.x    <= i_group_x;
            r_s1_group.y    <= i_group_y;
            r_s1_group.pix  <= i_group_pixels;
            r_s1_group.peak <= i_group_peak;
            r_s1_last       <= i_last_group;
        end
    end

    // stage 2: absolute differences
    nss_terms u_terms (
        .i_cfg   (r_cfg),
        .i_group (r_s1_group),
        .o_terms (terms)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_terms <= terms;
            r_s2_last  <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: score sum, running minimum, frame bookkeeping
    // ------------------------------------------------------------------
    logic [nss_pkg::SCORE_W-1:0] r_min, n_min;
    logic [nss_pkg::INDEX_W-1:0] r_best, n_best;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;
    logic [nss_pkg::SCORE_W-1:0] score;
    logic [CNT_W+nss_pkg::INDEX_W-1:0] cnt_ext;
    logic                        in_budget;

    logic [nss_pkg::INDEX_W-1:0] r_out_index, n_out_index;
    logic [nss_pkg::SCORE_W-1:0] r_out_score, n_out_score;
    logic                        r_out_ovf, n_out_ovf;

    // pixel and peak differences are whole units, scaled by 16 to q12.4
    assign score = nss_pkg::SCORE_W'(r_s2_terms.dx)
                 + nss_pkg::SCORE_W'(r_s2_terms.dy)
                 + nss_pkg::SCORE_W'({r_s2_terms.dpix, {nss_pkg::FRAC_W{1'b0}}})
                 + nss_pkg::SCORE_W'({r_s2_terms.dpeak, {nss_pkg::FRAC_W{1'b0}}});

    assign in_budget = (r_cnt < CNT_MAX);
    // index reported modulo 64 when the group budget is larger
    assign cnt_ext   = {{nss_pkg::INDEX_W{1'b0}}, r_cnt};

    always_comb begin
        n_min = r_min;
        n_best = r_best;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_out_index = r_out_index;
        n_out_score = r_out_score;
        n_out_ovf = r_out_ovf;
        if (s2_go) begin
            if (in_budget) begin
                // strict less-than keeps the first group on a tie
                if (score < r_min) begin
                    n_min  = score;
                    n_best = cnt_ext[nss_pkg::INDEX_W-1:0];
                end
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
            if (r_s2_last) begin
                n_out_index = n_best;
                n_out_score = n_min;
                n_out_ovf   = n_ovf;
                // fresh frame
                n_min  = '1;
                n_best = '0;
                n_cnt  = '0;
                n_ovf  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '1;
            r_best <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_min  <= n_min;
            r_best <= n_best;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && r_s2_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_score <= n_out_score;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_index;
    assign o_best_score = r_out_score;
    assign o_overflow   = r_out_ovf;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `NSS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_MAX,
        "group count past budget")
    `NSS_ASSERT(a_ovf_needs_full, i_clk, i_rst_n, r_ovf |-> (r_cnt == CNT_MAX),
        "overflow before budget full")
    `NSS_ASSERT(a_frame_clear, i_clk, i_rst_n,
        (s2_go && r_s2_last) |=> (r_cnt == '0 && r_min == '1 && !r_ovf),
        "frame state not cleared")
    `NSS_ASSERT(a_min_monotonic, i_clk, i_rst_n,
        (r_s2_valid && !r_s2_last) |=> (r_min <= $past(r_min)),
        "running minimum grew")

endmodule
